@@ src/ppp_pkg.sv @@
// ----------------------------------------------------------------------------
// Projection pixel preprocess package
// Shared item and configuration types, register indexes and fixed-point
// constants for the pixel preprocessing pipeline.
// ----------------------------------------------------------------------------
package ppp_pkg;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_FLATFIELD_ENABLE = 2'd0;
   localparam logic [1:0] CSR_NEGLOG_ENABLE    = 2'd1;
   localparam logic [1:0] CSR_WEIGHT_ENABLE    = 2'd2;

   // Saturation limits of the signed Q15.16 working value.
   localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

   // ln(2) in Q30.
   localparam logic [29:0] LN2_Q30 = 30'd744261118;

   typedef struct packed {
      logic flatfield_enable;
      logic neglog_enable;
      logic weight_enable;
   } cfg_type;

   // One pixel as it travels between the pipeline sections.
   typedef struct packed {
      logic signed [31:0] value;
      logic               overflow;
      logic [17:0]        weight;
   } pixel_item_type;

endpackage

@@ src/ppp_flatfield.sv @@
// ----------------------------------------------------------------------------
// Flat-field section
// Two stages: dark subtraction times reciprocal gain (with flat-field off,
// the raw count in Q16 instead), then saturation to the signed Q15.16 range.
// ----------------------------------------------------------------------------
module ppp_flatfield (
   input  logic                    clock,
   input  logic                    reset,
   input  ppp_pkg::cfg_type        cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [15:0]             raw_pixel,
   input  logic [15:0]             dark_level,
   input  logic [17:0]             gain_recip,
   input  logic [17:0]             fdk_weight,
   input  logic                    out_ready,
   output logic                    out_valid,
   output ppp_pkg::pixel_item_type out_item
);

   localparam int NUM_STAGES = 2;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES:0]   ready;

   logic signed [16:0] diff;
   logic signed [18:0] gain_s;

   logic signed [35:0] s0_product_in, s0_product_ff;
   logic [17:0]        s0_weight_in, s0_weight_ff;

   logic                    fits;
   ppp_pkg::pixel_item_type s1_item_in, s1_item_ff;

   // A stage takes new data when it is empty or its content moves on.
   always_comb begin
      ready[NUM_STAGES] = out_ready;
      for (int i = NUM_STAGES - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) valid_ff[0] <= in_valid;
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (ready[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   assign diff   = $signed({1'b0, raw_pixel}) - $signed({1'b0, dark_level});
   assign gain_s = $signed({1'b0, gain_recip});

   assign s0_product_in = cfg.flatfield_enable ? diff * gain_s
                                               : $signed({4'b0000, raw_pixel, 16'h0000});
   assign s0_weight_in  = fdk_weight;

   assign fits = (&s0_product_ff[35:31]) || !(|s0_product_ff[35:31]);

   always_comb begin
      s1_item_in.weight   = s0_weight_ff;
      s1_item_in.overflow = !fits;
      if (fits) begin
         s1_item_in.value = s0_product_ff[31:0];
      end else if (s0_product_ff[35]) begin
         s1_item_in.value = ppp_pkg::SAT_MIN;
      end else begin
         s1_item_in.value = ppp_pkg::SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         s0_product_ff <= s0_product_in;
         s0_weight_ff  <= s0_weight_in;
      end
      if (ready[1]) begin
         s1_item_ff <= s1_item_in;
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[NUM_STAGES-1];
   assign out_item  = s1_item_ff;

endmodule

@@ src/ppp_neglog.sv @@
// ----------------------------------------------------------------------------
// Negative log section
// Eight stages: leading-one search, normalize, table index, table read,
// interpolation, log2 assembly, scale by ln2, sign and bypass.
// ----------------------------------------------------------------------------
module ppp_neglog #(
   parameter int LOG_TABLE_ENTRIES = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ppp_pkg::cfg_type        cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  ppp_pkg::pixel_item_type in_item,
   input  logic                    out_ready,
   output logic                    out_valid,
   output ppp_pkg::pixel_item_type out_item
);

   localparam int NUM_STAGES = 8;
   localparam int NW         = $clog2(LOG_TABLE_ENTRIES + 1);
   localparam int PW         = 30 + NW;

   // log2(1 + i/N) in Q16 by repeated squaring in Q30.
   function automatic logic [16:0] log_entry(input int i);
      logic [63:0] x;
      logic [63:0] r;
      x = ((64'(LOG_TABLE_ENTRIES) + 64'(i)) << 30) / 64'(LOG_TABLE_ENTRIES);
      r = '0;
      for (int k = 0; k < 20; k++) begin
         x = (x * x) >> 30;
         r = r << 1;
         if (x >= (64'd1 << 31)) begin
            r = r | 64'd1;
            x = x >> 1;
         end
      end
      return 17'((r + 64'd8) >> 4);
   endfunction

   logic [16:0] log_rom [0:LOG_TABLE_ENTRIES];

   for (genvar g = 0; g <= LOG_TABLE_ENTRIES; g++) begin : g_rom
      assign log_rom[g] = log_entry(g);
   end

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES:0]   ready;

   // Stage 0: leading-one search.
   ppp_pkg::pixel_item_type s0_item_ff;
   logic       s0_pos_in, s0_pos_ff;
   logic [4:0] s0_exp_in, s0_exp_ff;
   // Stage 1: normalize.
   ppp_pkg::pixel_item_type s1_item_ff;
   logic        s1_pos_ff;
   logic [4:0]  s1_exp_ff;
   logic [30:0] shifted;
   logic [29:0] s1_mant_in, s1_mant_ff;
   // Stage 2: table index and interpolation weight.
   ppp_pkg::pixel_item_type s2_item_ff;
   logic          s2_pos_ff;
   logic [4:0]    s2_exp_ff;
   logic [PW-1:0] idx_prod;
   logic [NW-1:0] s2_idx_in, s2_idx_ff;
   logic [29:0]   s2_rem_in, s2_rem_ff;
   // Stage 3: table read.
   ppp_pkg::pixel_item_type s3_item_ff;
   logic          s3_pos_ff;
   logic [4:0]    s3_exp_ff;
   logic [29:0]   s3_rem_ff;
   logic [NW-1:0] idx_next;
   logic [16:0]   s3_t0_ff, s3_t1_ff;
   // Stage 4: interpolation.
   ppp_pkg::pixel_item_type s4_item_ff;
   logic        s4_pos_ff;
   logic [4:0]  s4_exp_ff;
   logic [16:0] s4_t0_ff;
   logic [16:0] delta;
   logic [47:0] interp_prod;
   logic [17:0] s4_interp_in, s4_interp_ff;
   // Stage 5: log2 and magnitude.
   ppp_pkg::pixel_item_type s5_item_ff;
   logic        s5_pos_ff;
   logic [17:0] frac;
   logic signed [5:0]  exp_s;
   logic signed [22:0] log2_val;
   logic [21:0] s5_mag_in, s5_mag_ff;
   logic        s5_neg_in, s5_neg_ff;
   // Stage 6: scale by ln2.
   ppp_pkg::pixel_item_type s6_item_ff;
   logic        s6_pos_ff;
   logic        s6_neg_ff;
   logic [51:0] ln_prod;
   logic [21:0] s6_res_in, s6_res_ff;
   // Stage 7: sign and bypass.
   ppp_pkg::pixel_item_type s7_item_in, s7_item_ff;

   always_comb begin
      ready[NUM_STAGES] = out_ready;
      for (int i = NUM_STAGES - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) valid_ff[0] <= in_valid;
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (ready[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   assign s0_pos_in = !in_item.value[31] && (|in_item.value[30:0]);

   always_comb begin
      s0_exp_in = '0;
      for (int b = 0; b < 31; b++) begin
         if (in_item.value[b]) s0_exp_in = 5'(b);
      end
   end

   // The leading one lands on bit 30 and drops out of the mantissa.
   assign shifted    = s0_item_ff.value[30:0] << (5'd30 - s0_exp_ff);
   assign s1_mant_in = shifted[29:0];

   assign idx_prod  = PW'(s1_mant_ff) * PW'(LOG_TABLE_ENTRIES);
   assign s2_idx_in = idx_prod[PW-1:30];
   assign s2_rem_in = idx_prod[29:0];

   assign idx_next = s2_idx_ff + NW'(1);

   assign delta        = s3_t1_ff - s3_t0_ff;
   assign interp_prod  = 48'(delta) * 48'(s3_rem_ff) + (48'd1 << 29);
   assign s4_interp_in = interp_prod[47:30];

   assign frac      = 18'(s4_t0_ff) + s4_interp_ff;
   assign exp_s     = $signed({1'b0, s4_exp_ff}) - 6'sd16;
   assign log2_val  = $signed({exp_s[5], exp_s, 16'h0000}) + $signed({5'b00000, frac});
   assign s5_neg_in = log2_val[22];
   assign s5_mag_in = log2_val[22] ? 22'(-log2_val) : 22'(log2_val);

   assign ln_prod   = 52'(s5_mag_ff) * 52'(ppp_pkg::LN2_Q30) + (52'd1 << 29);
   assign s6_res_in = ln_prod[51:30];

   always_comb begin
      s7_item_in = s6_item_ff;
      if (cfg.neglog_enable) begin
         if (!s6_pos_ff) begin
            s7_item_in.value = '0;
         end else if (s6_neg_ff) begin
            s7_item_in.value = $signed(32'(s6_res_ff));
         end else begin
            s7_item_in.value = -$signed(32'(s6_res_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         s0_item_ff <= in_item;
         s0_pos_ff  <= s0_pos_in;
         s0_exp_ff  <= s0_exp_in;
      end
      if (ready[1]) begin
         s1_item_ff <= s0_item_ff;
         s1_pos_ff  <= s0_pos_ff;
         s1_exp_ff  <= s0_exp_ff;
         s1_mant_ff <= s1_mant_in;
      end
      if (ready[2]) begin
         s2_item_ff <= s1_item_ff;
         s2_pos_ff  <= s1_pos_ff;
         s2_exp_ff  <= s1_exp_ff;
         s2_idx_ff  <= s2_idx_in;
         s2_rem_ff  <= s2_rem_in;
      end
      if (ready[3]) begin
         s3_item_ff <= s2_item_ff;
         s3_pos_ff  <= s2_pos_ff;
         s3_exp_ff  <= s2_exp_ff;
         s3_rem_ff  <= s2_rem_ff;
         s3_t0_ff   <= log_rom[s2_idx_ff];
         s3_t1_ff   <= log_rom[idx_next];
      end
      if (ready[4]) begin
         s4_item_ff   <= s3_item_ff;
         s4_pos_ff    <= s3_pos_ff;
         s4_exp_ff    <= s3_exp_ff;
         s4_t0_ff     <= s3_t0_ff;
         s4_interp_ff <= s4_interp_in;
      end
      if (ready[5]) begin
         s5_item_ff <= s4_item_ff;
         s5_pos_ff  <= s4_pos_ff;
         s5_mag_ff  <= s5_mag_in;
         s5_neg_ff  <= s5_neg_in;
      end
      if (ready[6]) begin
         s6_item_ff <= s5_item_ff;
         s6_pos_ff  <= s5_pos_ff;
         s6_neg_ff  <= s5_neg_ff;
         s6_res_ff  <= s6_res_in;
      end
      if (ready[7]) begin
         s7_item_ff <= s7_item_in;
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[NUM_STAGES-1];
   assign out_item  = s7_item_ff;

   // The log2 table rises monotonically, so the interpolation step is never negative.
   a_table_monotonic: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> s3_t1_ff >= s3_t0_ff)
      else $error("log2 table entries out of order at the read stage");

endmodule

@@ src/ppp_weight.sv @@
// ----------------------------------------------------------------------------
// Weighting section
// Three stages: product with the cone-beam weight, rounding to Q16, then
// sign restore with saturation. The last stage is the result register.
// ----------------------------------------------------------------------------
module ppp_weight (
   input  logic                    clock,
   input  logic                    reset,
   input  ppp_pkg::cfg_type        cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  ppp_pkg::pixel_item_type in_item,
   input  logic                    out_ready,
   output logic                    out_valid,
   output ppp_pkg::pixel_item_type out_item
);

   localparam int NUM_STAGES = 3;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES:0]   ready;

   logic signed [18:0]      weight_s;
   ppp_pkg::pixel_item_type s0_item_ff;
   logic signed [50:0]      s0_prod_in, s0_prod_ff;

   ppp_pkg::pixel_item_type s1_item_ff;
   logic [50:0]             prod_mag;
   logic [50:0]             prod_round;
   logic [34:0]             s1_round_in, s1_round_ff;
   logic                    s1_neg_in, s1_neg_ff;

   logic signed [35:0]      signed_val;
   logic                    fits;
   ppp_pkg::pixel_item_type s2_item_in, s2_item_ff;

   always_comb begin
      ready[NUM_STAGES] = out_ready;
      for (int i = NUM_STAGES - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) valid_ff[0] <= in_valid;
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (ready[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   assign weight_s   = $signed({1'b0, in_item.weight});
   assign s0_prod_in = in_item.value * weight_s;

   // Round half away from zero on the magnitude.
   assign prod_mag    = s0_prod_ff[50] ? 51'(-s0_prod_ff) : 51'(s0_prod_ff);
   assign prod_round  = prod_mag + (51'd1 << 15);
   assign s1_round_in = prod_round[50:16];
   assign s1_neg_in   = s0_prod_ff[50];

   assign signed_val = s1_neg_ff ? -$signed({1'b0, s1_round_ff})
                                 : $signed({1'b0, s1_round_ff});
   assign fits = (&signed_val[35:31]) || !(|signed_val[35:31]);

   always_comb begin
      s2_item_in = s1_item_ff;
      if (cfg.weight_enable) begin
         if (fits) begin
            s2_item_in.value = signed_val[31:0];
         end else begin
            s2_item_in.overflow = 1'b1;
            s2_item_in.value    = signed_val[35] ? ppp_pkg::SAT_MIN : ppp_pkg::SAT_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         s0_item_ff <= in_item;
         s0_prod_ff <= s0_prod_in;
      end
      if (ready[1]) begin
         s1_item_ff  <= s0_item_ff;
         s1_round_ff <= s1_round_in;
         s1_neg_ff   <= s1_neg_in;
      end
      if (ready[2]) begin
         s2_item_ff <= s2_item_in;
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[NUM_STAGES-1];
   assign out_item  = s2_item_ff;

endmodule

@@ src/projection_pixel_preprocess.sv @@
// ----------------------------------------------------------------------------
// Projection pixel preprocess
// Flat-field correction, clamped negative log and cone-beam weighting of one
// detector pixel per item, in signed Q15.16 with saturation.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake            Payload
//   req_      in          req_valid/req_stall  raw_pixel, dark_level,
//                                              gain_recip, fdk_weight
//   rsp_      out         rsp_valid/rsp_stall  pixel_value, overflow
//   csr_      in          csr_write_enable     csr_index, csr_write_data
//
// One item enters per cycle while req_stall is low and passes through two
// flat-field stages, eight negative log stages and three weighting stages,
// the last of which is the result register.
// Every stage holds a valid bit and moves whenever the stage after it is
// empty or moving, so bubbles close up while rsp_stall is high; req_stall
// rises only when all 13 stages hold items and the result is stalled.
// Reset clears the valid bits and sets the registers to flat-field on,
// negative log on and weighting off. No memory needs clearing.
//
// Negative log and weighting carry a bypass: a disabled section passes its
// value and overflow flag through unchanged, keeping the same latency. The
// log2 table is a constant ROM of LOG_TABLE_ENTRIES + 1 entries with two
// registered read ports (the entry and its neighbor for interpolation).
// ----------------------------------------------------------------------------
module projection_pixel_preprocess #(
   parameter int LOG_TABLE_ENTRIES = 256
) (
   input  logic               clock,
   input  logic               reset,
   // Input items.
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_raw_pixel,
   input  logic [15:0]        req_dark_level,
   input  logic [17:0]        req_gain_recip,
   input  logic [17:0]        req_fdk_weight,
   // Result items.
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pixel_value,
   output logic               rsp_overflow,
   // Configuration writes.
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [0:0]         csr_write_data
);

   ppp_pkg::cfg_type cfg_ff;

   logic                    ff_in_ready;
   logic                    ff_out_valid;
   ppp_pkg::pixel_item_type ff_out_item;
   logic                    nl_in_ready;
   logic                    nl_out_valid;
   ppp_pkg::pixel_item_type nl_out_item;
   logic                    wt_in_ready;
   ppp_pkg::pixel_item_type wt_out_item;

   // Configuration registers. Writes to an unused index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flatfield_enable <= 1'b1;
         cfg_ff.neglog_enable    <= 1'b1;
         cfg_ff.weight_enable    <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ppp_pkg::CSR_FLATFIELD_ENABLE: cfg_ff.flatfield_enable <= csr_write_data[0];
            ppp_pkg::CSR_NEGLOG_ENABLE:    cfg_ff.neglog_enable    <= csr_write_data[0];
            ppp_pkg::CSR_WEIGHT_ENABLE:    cfg_ff.weight_enable    <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   ppp_flatfield u_flatfield (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_valid),
      .in_ready   (ff_in_ready),
      .raw_pixel  (req_raw_pixel),
      .dark_level (req_dark_level),
      .gain_recip (req_gain_recip),
      .fdk_weight (req_fdk_weight),
      .out_ready  (nl_in_ready),
      .out_valid  (ff_out_valid),
      .out_item   (ff_out_item)
   );

   ppp_neglog #(
      .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
   ) u_neglog (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (ff_out_valid),
      .in_ready  (nl_in_ready),
      .in_item   (ff_out_item),
      .out_ready (wt_in_ready),
      .out_valid (nl_out_valid),
      .out_item  (nl_out_item)
   );

   ppp_weight u_weight (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (nl_out_valid),
      .in_ready  (wt_in_ready),
      .in_item   (nl_out_item),
      .out_ready (!rsp_stall),
      .out_valid (rsp_valid),
      .out_item  (wt_out_item)
   );

   assign req_stall       = !ff_in_ready;
   assign rsp_pixel_value = wt_out_item.value;
   assign rsp_overflow    = wt_out_item.overflow;

   // The input side can only back up when every stage is full and the result waits.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while the pipeline still had room");

   // A negative log result without weighting stays below 12 in magnitude.
   a_neglog_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cfg_ff.neglog_enable && !cfg_ff.weight_enable
      |-> (rsp_pixel_value <= 32'sd786432) && (rsp_pixel_value >= -32'sd786432))
      else $error("negative log result outside its range");

   // Saturation is the only source of the flag, so a flagged value sits at a limit
   // unless a later section has rescaled it.
   a_overflow_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow && !cfg_ff.neglog_enable && !cfg_ff.weight_enable
      |-> (rsp_pixel_value == ppp_pkg::SAT_MAX) || (rsp_pixel_value == ppp_pkg::SAT_MIN))
      else $error("overflow flagged on a value that is not saturated");

endmodule

@@ bench/tb_projection_pixel_preprocess.sv @@
// ----------------------------------------------------------------------------
// Projection pixel preprocess testbench
// Drives detector pixels through the flat-field, negative log and weighting
// pipeline and checks every result against a typed value or a fixed-point
// predictor. A short corner-pixel table runs first, then phases of random
// pixels under several register settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_projection_pixel_preprocess;

   localparam int LOG_TABLE_ENTRIES = 256;

   // Saturation limits of the Q15.16 working value, held in 64-bit math.
   localparam longint Q16_MAX = 2147483647;
   localparam longint Q16_MIN = -Q16_MAX - 1;

   // ln(2) in Q30.
   localparam longint unsigned LN2_FIXED = 744261118;

   // The index above the last register; writes there must change nothing.
   localparam logic [1:0] CSR_UNUSED_INDEX = 2'd3;

   localparam int RANDOM_ITEMS     = 825;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int PIPE_LATENCY     = 13;
   localparam int WATCHDOG_LIMIT   = 2000;

   typedef struct packed {
      logic signed [31:0] pixel_value;
      logic               overflow;
   } pixel_result_type;

   // One row of the directed table. Where has_typed_result is set, the
   // expected result is the one typed into the row; otherwise the predictor
   // supplies it.
   typedef struct packed {
      ppp_pkg::cfg_type   setting;
      logic [15:0]        raw_pixel;
      logic [15:0]        dark_level;
      logic [17:0]        gain_recip;
      logic [17:0]        fdk_weight;
      logic               has_typed_result;
      logic signed [31:0] pixel_value;
      logic               overflow;
   } stimulus_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [15:0]        req_raw_pixel;
   logic [15:0]        req_dark_level;
   logic [17:0]        req_gain_recip;
   logic [17:0]        req_fdk_weight;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_pixel_value;
   logic               rsp_overflow;
   logic               csr_write_enable;
   logic [1:0]         csr_index;
   logic [0:0]         csr_write_data;

   // The bench's copy of the registers, the log2 mantissa ROM and the
   // results still owed by the pipeline, oldest first.
   ppp_pkg::cfg_type   active_cfg;
   longint unsigned    log2_mantissa [0:LOG_TABLE_ENTRIES];
   pixel_result_type   expected_pixels [$];
   stimulus_row_type   directed_rows [$];
   pixel_result_type   oldest_pixel;

   int error_count     = 0;
   int items_accepted  = 0;
   int random_sent     = 0;
   int results_checked = 0;
   int config_writes   = 0;

   // Receiver controls, written by the stimulus with nonblocking updates.
   int holds_requested = 0;
   bit receiver_busy   = 1'b0;

   projection_pixel_preprocess #(
      .LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_raw_pixel    (req_raw_pixel),
      .req_dark_level   (req_dark_level),
      .req_gain_recip   (req_gain_recip),
      .req_fdk_weight   (req_fdk_weight),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_overflow     (rsp_overflow),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // log2(1 + i/N) in Q16. The fraction (N+i)/N is squared twenty times in
   // Q30; each time the square reaches two, one result bit is set and the
   // square is halved. The 20-bit result is then rounded to the nearest Q16 value.
   function automatic longint unsigned log2_entry(longint unsigned i);
      longint unsigned n;
      longint unsigned x;
      longint unsigned r;
      int              k;
      n = LOG_TABLE_ENTRIES;
      x = ((n + i) << 30) / n;
      r = 0;
      for (k = 0; k < 20; k++) begin
         x = (x * x) >> 30;
         r = r << 1;
         if (x >= (64'd1 << 31)) begin
            r = r | 64'd1;
            x = x >> 1;
         end
      end
      return (r + 8) >> 4;
   endfunction

   // -ln(v) for a Q15.16 value, clamped to zero for v <= 0. The exponent is
   // the leading-one position; the 30 bits below it index the ROM and set
   // the interpolation weight toward the next entry.
   function automatic longint neg_ln_q16(longint v);
      longint unsigned magnitude;
      longint unsigned mantissa;
      longint unsigned scaled;
      longint unsigned index;
      longint unsigned remainder;
      longint unsigned lower;
      longint unsigned upper;
      longint unsigned fraction;
      longint unsigned abs_log2;
      longint unsigned rounded;
      longint          log2_value;
      int              exponent;
      if (v <= 0)
         return 0;
      magnitude = v;
      exponent  = 30;
      while (exponent > 0 && magnitude[exponent] == 1'b0)
         exponent--;
      mantissa  = (magnitude << (30 - exponent)) - (64'd1 << 30);
      scaled    = mantissa * LOG_TABLE_ENTRIES;
      index     = scaled >> 30;
      remainder = scaled & ((64'd1 << 30) - 1);
      lower     = log2_mantissa[index];
      upper     = log2_mantissa[index + 1];
      fraction  = lower + (((upper - lower) * remainder + (64'd1 << 29)) >> 30);
      log2_value = longint'(exponent - 16) * 65536 + longint'(fraction);
      // Scale by ln2 on the magnitude so that rounding goes half away from zero.
      abs_log2 = (log2_value < 0) ? -log2_value : log2_value;
      rounded  = (abs_log2 * LN2_FIXED + (64'd1 << 29)) >> 30;
      return (log2_value < 0) ? longint'(rounded) : -longint'(rounded);
   endfunction

   function automatic longint saturate_q16(longint v);
      if (v > Q16_MAX)
         return Q16_MAX;
      if (v < Q16_MIN)
         return Q16_MIN;
      return v;
   endfunction

   // Expected result of one pixel under the given register setting.
   function automatic pixel_result_type corrected_pixel(ppp_pkg::cfg_type setting,
                                                        longint raw, longint dark,
                                                        longint gain, longint weight);
      pixel_result_type result;
      longint           v;
      longint           clipped;
      longint           product;
      longint unsigned  magnitude;
      longint unsigned  rounded;
      result.overflow = 1'b0;
      // Flat-field gives an exact Q16 product; with it off the raw count is
      // simply moved to Q16. Either way the value is saturated here.
      if (setting.flatfield_enable)
         v = (raw - dark) * gain;
      else
         v = raw * 65536;
      clipped = saturate_q16(v);
      result.overflow = result.overflow | (clipped != v);
      v = clipped;
      if (setting.neglog_enable)
         v = neg_ln_q16(v);
      // Weighting rounds the Q32 product to Q16, half away from zero.
      if (setting.weight_enable) begin
         product   = v * weight;
         magnitude = (product < 0) ? -product : product;
         rounded   = (magnitude + 64'd32768) >> 16;
         v = (product < 0) ? -longint'(rounded) : longint'(rounded);
         clipped = saturate_q16(v);
         result.overflow = result.overflow | (clipped != v);
         v = clipped;
      end
      result.pixel_value = v[31:0];
      return result;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Idle lengths drawn from three ranges: mostly the shortest, now and then the longest.
   function automatic int unsigned idle_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 80)
         return $urandom_range(1, 3);
      if (pick < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Offers one item and returns at the edge where it is accepted, leaving
   // req_valid high so that a following item can go back to back.
   task automatic send_pixel(input logic [15:0] raw, input logic [15:0] dark,
                             input logic [17:0] gain, input logic [17:0] weight,
                             input logic has_typed_result,
                             input pixel_result_type typed_result);
      req_valid      <= 1'b1;
      req_raw_pixel  <= raw;
      req_dark_level <= dark;
      req_gain_recip <= gain;
      req_fdk_weight <= weight;
      do
         @(posedge clock);
      while (req_stall);
      if (has_typed_result)
         expected_pixels.push_back(typed_result);
      else
         expected_pixels.push_back(corrected_pixel(active_cfg, raw, dark, gain, weight));
      items_accepted++;
   endtask

   task automatic idle_sender(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stops offering items until every owed result has come back. It waits on the
   // clock before it first checks, so the next item is offered in a later time step.
   task automatic drain_results();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (expected_pixels.size() != 0);
   endtask

   // Rewrites all three registers on an idle pipeline. A write to the unused
   // index follows, which must leave the setting alone.
   task automatic write_config(input ppp_pkg::cfg_type setting);
      int n;
      drain_results();
      for (n = 0; n < 4; n++) begin
         csr_write_enable <= 1'b1;
         case (n)
            0: begin
               csr_index      <= ppp_pkg::CSR_FLATFIELD_ENABLE;
               csr_write_data <= setting.flatfield_enable;
            end
            1: begin
               csr_index      <= ppp_pkg::CSR_NEGLOG_ENABLE;
               csr_write_data <= setting.neglog_enable;
            end
            2: begin
               csr_index      <= ppp_pkg::CSR_WEIGHT_ENABLE;
               csr_write_data <= setting.weight_enable;
            end
            default: begin
               csr_index      <= CSR_UNUSED_INDEX;
               csr_write_data <= 1'($urandom);
            end
         endcase
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      active_cfg = setting;
      config_writes++;
   endtask

   // Most random pixels look like real detector data: a modest dark level,
   // a raw count above it and a small reciprocal gain, so that the log stage
   // sees values across its whole range. The rest are raw noise over the
   // full field widths, or pixels at or below their dark level.
   task automatic send_random_pixel();
      logic [15:0] raw;
      logic [15:0] dark;
      logic [17:0] gain;
      logic [17:0] weight;
      int unsigned kind;
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
         raw    = 16'($urandom);
         dark   = 16'($urandom);
         gain   = 18'($urandom);
         weight = 18'($urandom);
      end else begin
         dark = 16'($urandom_range(0, 3000));
         if (kind < 25)
            raw = 16'($urandom_range(0, dark));
         else
            raw = dark + 16'($urandom_range(0, 65535 - dark));
         if (kind < 60)
            gain = 18'($urandom_range(1, 1024));
         else if (kind < 85)
            gain = 18'($urandom_range(1, 65536));
         else
            gain = 18'($urandom_range(0, 262143));
         if (kind < 70)
            weight = 18'($urandom_range(49152, 81920));
         else
            weight = 18'($urandom_range(0, 262143));
      end
      send_pixel(raw, dark, gain, weight, 1'b0, '0);
      random_sent++;
   endtask

   task automatic table_row(input ppp_pkg::cfg_type setting,
                            input logic [15:0] raw, input logic [15:0] dark,
                            input logic [17:0] gain, input logic [17:0] weight,
                            input logic has_typed_result,
                            input logic signed [31:0] value, input logic overflow);
      stimulus_row_type row;
      row.setting          = setting;
      row.raw_pixel        = raw;
      row.dark_level       = dark;
      row.gain_recip       = gain;
      row.fdk_weight       = weight;
      row.has_typed_result = has_typed_result;
      row.pixel_value      = value;
      row.overflow         = overflow;
      directed_rows.push_back(row);
   endtask

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------

   // The receiver stalls at random while receiver_busy is set. Each new hold
   // request from the stimulus makes it refuse results for a long stretch,
   // long enough for the whole pipeline to fill and push back on the input.
   initial begin : receiver
      int holds_served;
      holds_served = 0;
      rsp_stall    = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != holds_requested) begin
            holds_served++;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (receiver_busy && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat (idle_length()) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Every accepted result is checked against the oldest owed one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (expected_pixels.size() == 0) begin
            $error("result with no item pending: pixel_value %0d, overflow %0b",
                   rsp_pixel_value, rsp_overflow);
            error_count++;
         end else begin
            oldest_pixel = expected_pixels.pop_front();
            if (rsp_pixel_value !== oldest_pixel.pixel_value) begin
               $error("pixel_value: expected %0d, actual %0d",
                      oldest_pixel.pixel_value, rsp_pixel_value);
               error_count++;
            end
            if (rsp_overflow !== oldest_pixel.overflow) begin
               $error("overflow: expected %0b, actual %0b",
                      oldest_pixel.overflow, rsp_overflow);
               error_count++;
            end
         end
      end
   end

   // The run is declared hung when nothing moves on any port for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             csr_write_enable)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no handshake for %0d cycles, %0d results still owed",
               WATCHDOG_LIMIT, expected_pixels.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   initial begin : stimulus
      ppp_pkg::cfg_type setting;
      stimulus_row_type row;
      int               r;
      int               k;
      int               phase;
      int               phase_items;
      bit               sender_gaps;

      for (r = 0; r <= LOG_TABLE_ENTRIES; r++)
         log2_mantissa[r] = log2_entry(r);

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_raw_pixel    = '0;
      req_dark_level   = '0;
      req_gain_recip   = '0;
      req_fdk_weight   = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      // Registers after reset: flat-field on, negative log on, weighting off.
      active_cfg       = 3'b110;

      // Setting bits are flat-field, negative log, weighting.
      //        setting  raw    dark   gain    weight typed value         ovf
      // Reset setting: equal counts, pixels below dark and a zero gain all
      // clamp to zero; a pixel far below dark still flags the flat-field
      // saturation. The smallest positive value gives the largest log.
      table_row(3'b110,  1000,  1000,  65536,      0, 1, 0,            0);
      table_row(3'b110,     0, 65535, 262143,      0, 1, 0,            1);
      table_row(3'b110, 50000,   100,      0,      0, 1, 0,            0);
      table_row(3'b110,     2,     1,  65536,      0, 1, 0,            0);
      table_row(3'b110,     1,     0,      1,      0, 0, 0,            0);
      table_row(3'b110, 65535,     0, 262143,      0, 0, 0,            0);
      // Flat-field alone: saturation at both ends and exact small products.
      table_row(3'b100, 65535,     0, 262143,      0, 1, 32'h7FFFFFFF, 1);
      table_row(3'b100,     0, 65535, 262143,      0, 1, 32'h80000000, 1);
      table_row(3'b100,     1,     0,  65536,      0, 1, 65536,        0);
      table_row(3'b100,     0,     1,      3,      0, 1, -3,           0);
      // Everything off: the raw count moves to Q16 and saturates from 32768.
      table_row(3'b000, 32767,     0,      0,      0, 1, 32'h7FFF0000, 0);
      table_row(3'b000, 32768,     0,      0,      0, 1, 32'h7FFFFFFF, 1);
      table_row(3'b000,     0, 65535, 262143, 262143, 1, 0,            0);
      // Log alone on raw counts, including the saturated top of the range.
      table_row(3'b010,     1,     0,      0,      0, 1, 0,            0);
      table_row(3'b010,     0,     0,      0,      0, 1, 0,            0);
      table_row(3'b010, 65535,     0,      0,      0, 0, 0,            0);
      table_row(3'b010,   300,     0,      0,      0, 0, 0,            0);
      // Weighting alone: unit weight, overflow and a zero weight.
      table_row(3'b001,     1,     0,      0,  65536, 1, 65536,        0);
      table_row(3'b001, 32767,     0,      0, 262143, 1, 32'h7FFFFFFF, 1);
      table_row(3'b001,  1234,     0,      0,      0, 1, 0,            0);
      // Flat-field with weighting: ties round away from zero on both signs,
      // and a saturated value stays saturated through the weight.
      table_row(3'b101,     1,     0,      1,  32768, 1, 1,            0);
      table_row(3'b101,     0,     1,      1,  32768, 1, -1,           0);
      table_row(3'b101,     0, 65535, 262143, 262143, 1, 32'h80000000, 1);
      // All stages on, with negative log results scaled by large weights.
      table_row(3'b111, 60000,     0,  65535, 262143, 0, 0,            0);
      table_row(3'b111,     1,     0,      1, 262143, 0, 0,            0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < directed_rows.size(); r++) begin
         row = directed_rows[r];
         if (row.setting != active_cfg)
            write_config(row.setting);
         send_pixel(row.raw_pixel, row.dark_level, row.gain_recip, row.fdk_weight,
                    row.has_typed_result, {row.pixel_value, row.overflow});
      end

      // Random phases, each under its own register setting. The first two
      // use the extremes, all stages off and all on. Some phases run without
      // any idling on one side or the other.
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (phase == 0)
            setting = 3'b000;
         else if (phase == 1)
            setting = 3'b111;
         else
            setting = ppp_pkg::cfg_type'($urandom_range(0, 7));
         write_config(setting);
         sender_gaps   = ($urandom_range(0, 3) != 0);
         receiver_busy <= ($urandom_range(0, 3) != 0);
         phase_items   = $urandom_range(40, 120);
         if (phase_items > RANDOM_ITEMS - random_sent)
            phase_items = RANDOM_ITEMS - random_sent;
         for (k = 0; k < phase_items; k++) begin
            // Once, the receiver refuses results for a long stretch while
            // items keep coming back to back, so the pipeline fills and the
            // input stalls.
            if (phase == 2 && k == 10) begin
               holds_requested <= holds_requested + 1;
               repeat (40) send_random_pixel();
            end
            // Once, the sender stops in the middle of a phase until the
            // pipeline has emptied.
            if (phase == 3 && k == phase_items / 2)
               drain_results();
            send_random_pixel();
            if (sender_gaps && $urandom_range(0, 2) == 0)
               idle_sender(idle_length());
         end
         phase++;
      end

      drain_results();
      receiver_busy <= 1'b0;
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         $error("%0d results never arrived", expected_pixels.size());
         error_count++;
      end

      $display("Ran %0d pixels (%0d from the corner table) through %0d register settings;",
               items_accepted, directed_rows.size(), config_writes);
      $display("checked %0d results, with stalls on both sides and one full back-up.",
               results_checked);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
